// ----- hw/rtl/fcgi_pkg.sv -----
// fcgi_pkg: shared types and constants for the FastCGI record deframer
// no dependencies; imported by fcgi_step, fastcgi_record_deframer and tb_top

package fcgi_pkg;

    // parser phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_CONTENT = 2'd1;
    localparam logic [1:0] PH_PADDING = 2'd2;
    localparam logic [1:0] PH_HALTED  = 2'd3;

    // header byte positions
    localparam logic [2:0] HDR_TYPE    = 3'd1;
    localparam logic [2:0] HDR_ID_HI   = 3'd2;
    localparam logic [2:0] HDR_ID_LO   = 3'd3;
    localparam logic [2:0] HDR_LEN_HI  = 3'd4;
    localparam logic [2:0] HDR_LEN_LO  = 3'd5;
    localparam logic [2:0] HDR_PAD     = 3'd6;
    localparam logic [2:0] HDR_LAST    = 3'd7;

    // record types handled
    localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
    localparam logic [7:0] TYPE_STDOUT      = 8'd6;
    localparam logic [7:0] TYPE_STDERR      = 8'd7;

    // result kinds
    localparam logic [2:0] KIND_STDOUT  = 3'd0;
    localparam logic [2:0] KIND_STDERR  = 3'd1;
    localparam logic [2:0] KIND_CLOSED  = 3'd2;
    localparam logic [2:0] KIND_ENDED   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [1:0]  phase;
        logic [2:0]  hdr_cnt;
        logic [15:0] content_left;
        logic [7:0]  padding_left;
        logic [7:0]  record_type;
        logic [15:0] current_id;
    } t_state;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  out_kind;
        logic [15:0] record_id;
    } t_result;

endpackage

// ----- hw/rtl/fcgi_step.sv -----
// fcgi_step: next-state and result logic for one byte of the record stream
// depends on fcgi_pkg

module fcgi_step
    import fcgi_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output t_state      o_state,
    output logic        o_emit,
    output t_result     o_result
);

    t_state      n_st;
    logic [1:0]  after_ph;
    logic [15:0] n_left;
    logic [7:0]  n_pad;

    // phase once content is done: padding if any is due
    assign after_ph = (i_state.padding_left != 8'd0) ? PH_PADDING : PH_HEADER;
    assign n_left   = (i_state.content_left != 16'd0) ? i_state.content_left - 16'd1
                                                      : i_state.content_left;
    assign n_pad    = (i_state.padding_left != 8'd0) ? i_state.padding_left - 8'd1
                                                     : i_state.padding_left;

    always_comb begin
        n_st     = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        if (i_restart) begin
            n_st = '0;
        end else begin
            case (i_state.phase)
                PH_HEADER: begin
                    // gather header fields
                    case (i_state.hdr_cnt)
                        HDR_TYPE:   n_st.record_type  = i_data_byte;
                        HDR_ID_HI:  n_st.current_id   = {i_data_byte, 8'h00};
                        HDR_ID_LO:  n_st.current_id   = {i_state.current_id[15:8], i_data_byte};
                        HDR_LEN_HI: n_st.content_left = {i_data_byte, 8'h00};
                        HDR_LEN_LO: n_st.content_left = {i_state.content_left[15:8],
                                                         i_data_byte};
                        HDR_PAD:    n_st.padding_left = i_data_byte;
                        default:    ;
                    endcase
                    if (i_state.hdr_cnt != HDR_LAST) begin
                        n_st.hdr_cnt = i_state.hdr_cnt + 3'd1;
                    end else begin
                        // header complete: dispatch on record type
                        n_st.hdr_cnt = 3'd0;
                        case (i_state.record_type)
                            TYPE_STDOUT: begin
                                if (i_state.content_left != 16'd0) begin
                                    n_st.phase = PH_CONTENT;
                                end else begin
                                    n_st.phase        = after_ph;
                                    o_emit            = 1'b1;
                                    o_result.out_kind = KIND_CLOSED;
                                end
                            end
                            TYPE_STDERR: begin
                                n_st.phase = (i_state.content_left != 16'd0) ? PH_CONTENT
                                                                             : after_ph;
                            end
                            TYPE_END_REQUEST: begin
                                if (i_state.content_left != 16'd0) begin
                                    n_st.phase = PH_CONTENT;
                                end else begin
                                    n_st.phase        = after_ph;
                                    o_emit            = 1'b1;
                                    o_result.out_kind = KIND_ENDED;
                                end
                            end
                            default: begin
                                n_st.phase        = PH_HALTED;
                                o_emit            = 1'b1;
                                o_result.out_kind = KIND_UNKNOWN;
                            end
                        endcase
                    end
                end
                PH_CONTENT: begin
                    // count down content, pass stdout/stderr data bytes, end an end-request at its last byte
                    n_st.content_left = n_left;
                    if (n_left == 16'd0) begin
                        n_st.phase = after_ph;
                    end
                    if (i_state.record_type == TYPE_STDOUT) begin
                        o_emit            = 1'b1;
                        o_result.out_byte = i_data_byte;
                        o_result.out_kind = KIND_STDOUT;
                    end else if (i_state.record_type == TYPE_STDERR) begin
                        o_emit            = 1'b1;
                        o_result.out_byte = i_data_byte;
                        o_result.out_kind = KIND_STDERR;
                    end else if (n_left == 16'd0) begin
                        o_emit            = 1'b1;
                        o_result.out_kind = KIND_ENDED;
                    end
                end
                PH_PADDING: begin
                    // drop padding bytes
                    n_st.padding_left = n_pad;
                    if (n_pad == 8'd0) begin
                        n_st.phase = PH_HEADER;
                    end
                end
                default: ;
            endcase
            o_result.record_id = n_st.current_id;
        end
    end

    assign o_state = n_st;

endmodule

// ----- hw/rtl/fastcgi_record_deframer.sv -----
// fastcgi_record_deframer: top level of the FastCGI record deframer
// depends on fcgi_pkg and fcgi_step
//
// Usage:
//   input channel (i_in_valid / o_in_ready) carries one backend byte per beat,
//   with i_restart to discard the byte and return to header parsing.
//   output channel (o_out_valid / i_out_ready) carries zero or one result per
//   input beat: content byte, kind tag and request id of the current record.
// Pipeline: two register stages, input register then result register; an accepted
//   beat's result reaches the result register once the parser stage advances.
// Throughput: one byte per cycle while the output is not stalled; the per-byte work
//   is a single pass of counter and phase logic between the two registers.
// Reset: synchronous active-low i_rst_n empties both stages and puts the
//   parser in header phase with all counters and fields cleared.
// Stall: while i_out_ready is low with a result held, the input register keeps
//   its byte and o_in_ready drops once that register is full; no beat is lost.
// After an unknown record type the parser halts and ignores bytes until a
//   beat with i_restart set.

module fastcgi_record_deframer
    import fcgi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_out_kind,
    output logic [15:0] o_record_id
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_restart;
    t_state      r_st;
    t_state      n_st;
    logic        n_emit;
    t_result     n_res;
    logic        r_out_valid;
    t_result     r_res;
    logic        adv;

    // parser stage moves when the result register can take a beat
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    fcgi_step u_step (
        .i_state     (r_st),
        .i_data_byte (r_in_byte),
        .i_restart   (r_in_restart),
        .o_state     (n_st),
        .o_emit      (n_emit),
        .o_result    (n_res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_st <= n_st;
            end
            if (adv && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte    <= i_data_byte;
            r_in_restart <= i_restart;
        end
        if (adv && n_emit) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_res.out_byte;
    assign o_out_kind  = r_res.out_kind;
    assign o_record_id = r_res.record_id;

    // kind stays in its defined range
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_kind <= KIND_UNKNOWN))
        else $error("result kind out of range");

    // only data kinds carry a byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind != KIND_STDOUT && o_out_kind != KIND_STDERR)
        |-> (o_out_byte == 8'd0))
        else $error("non-data result carries a byte");

    // halt holds until a restart beat is processed
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == PH_HALTED && !(adv && r_in_restart)) |=> (r_st.phase == PH_HALTED))
        else $error("halt left without restart");

    // header counter is idle outside the header phase
    a_hdr_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase != PH_HEADER) |-> (r_st.hdr_cnt == 3'd0))
        else $error("header count nonzero outside header phase");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking testbench for fastcgi_record_deframer
// depends on fcgi_pkg and fastcgi_record_deframer; checks each result beat
// against a behavioral record parser fed by the same backend bytes

module tb_top;
    import fcgi_pkg::*;

    localparam int DRAIN_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_BEATS     = 150;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RANDOM_BEATS   = 320;

    // one backend byte as queued for the driver
    typedef struct {
        logic [7:0] data;
        logic       restart;
        bit         drain_first;
    } t_backend_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_restart   = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_out_kind;
    logic [15:0] o_record_id;

    t_backend_beat pending_beats[$];
    t_backend_beat cur_beat = '{data: 8'h00, restart: 1'b0, drain_first: 1'b0};
    t_result       due_results[$];
    t_state        parser = '0;

    int  total_beats    = 0;
    int  beats_accepted = 0;
    int  results_due    = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    int  sender_gap     = 0;
    int  drain_wait     = 0;
    int  recv_gap       = 0;
    int  holdoff_left   = 0;
    bit  holdoff_done   = 1'b0;
    bit  drain_next     = 1'b0;

    fastcgi_record_deframer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_kind  (o_out_kind),
        .o_record_id (o_record_id)
    );

    // clock and reset
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic t_result result_of(input logic [7:0] data_b, input logic [2:0] kind);
        return '{out_byte: data_b, out_kind: kind, record_id: parser.current_id};
    endfunction

    // record parser: advances on one backend byte, returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] data_b, input logic rst,
                                        output t_result res);
        res = '0;
        // restart wipes everything back to the header phase
        if (rst) begin
            parser = '0;
            parser.phase = PH_HEADER;
            return 1'b0;
        end
        case (parser.phase)
            PH_HEADER: begin
                case (parser.hdr_cnt)
                    HDR_TYPE:   parser.record_type  = data_b;
                    HDR_ID_HI:  parser.current_id   = {data_b, 8'h00};
                    HDR_ID_LO:  parser.current_id   = parser.current_id | {8'h00, data_b};
                    HDR_LEN_HI: parser.content_left = {data_b, 8'h00};
                    HDR_LEN_LO: parser.content_left = parser.content_left | {8'h00, data_b};
                    HDR_PAD:    parser.padding_left = data_b;
                    default:    ;
                endcase
                if (parser.hdr_cnt != HDR_LAST) begin
                    parser.hdr_cnt = parser.hdr_cnt + 3'd1;
                    return 1'b0;
                end
                parser.hdr_cnt = '0;
                if (parser.record_type inside {TYPE_STDOUT, TYPE_STDERR, TYPE_END_REQUEST}) begin
                    if (parser.content_left != 0) begin
                        parser.phase = PH_CONTENT;
                        return 1'b0;
                    end
                    parser.phase = (parser.padding_left != 0) ? PH_PADDING : PH_HEADER;
                    // empty stdout closes the stream, empty end-request ends at once
                    if (parser.record_type == TYPE_STDOUT) begin
                        res = result_of(8'h00, KIND_CLOSED);
                        return 1'b1;
                    end
                    if (parser.record_type == TYPE_END_REQUEST) begin
                        res = result_of(8'h00, KIND_ENDED);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                // unknown type halts until restart
                parser.phase = PH_HALTED;
                res = result_of(8'h00, KIND_UNKNOWN);
                return 1'b1;
            end
            PH_CONTENT: begin
                if (parser.content_left != 0) begin
                    parser.content_left = parser.content_left - 16'd1;
                end
                if (parser.content_left == 0) begin
                    parser.phase = (parser.padding_left != 0) ? PH_PADDING : PH_HEADER;
                end
                if (parser.record_type == TYPE_STDOUT) begin
                    res = result_of(data_b, KIND_STDOUT);
                    return 1'b1;
                end
                if (parser.record_type == TYPE_STDERR) begin
                    res = result_of(data_b, KIND_STDERR);
                    return 1'b1;
                end
                if (parser.content_left == 0) begin
                    res = result_of(8'h00, KIND_ENDED);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_PADDING: begin
                if (parser.padding_left != 0) begin
                    parser.padding_left = parser.padding_left - 8'd1;
                end
                if (parser.padding_left == 0) begin
                    parser.phase = PH_HEADER;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // idling only outside the tail, and not in every third window of 64 beats
    function automatic bit idle_allowed();
        return (beats_accepted + TAIL_BEATS < total_beats) && ((beats_accepted / 64) % 3 != 2);
    endfunction

    // stimulus builders
    task automatic add_beat(input logic [7:0] data_b, input logic rst = 1'b0);
        pending_beats.push_back('{data: data_b, restart: rst, drain_first: drain_next});
        drain_next = 1'b0;
    endtask

    task automatic add_restart();
        add_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic add_header(input logic [7:0] typ, input logic [15:0] id,
                              input logic [15:0] clen, input logic [7:0] plen,
                              input int n_bytes = 8);
        logic [7:0] hdr [8];
        hdr = '{8'($urandom_range(0, 255)), typ, id[15:8], id[7:0],
                clen[15:8], clen[7:0], plen, 8'($urandom_range(0, 255))};
        for (int i = 0; i < n_bytes; i++) begin
            add_beat(hdr[i]);
        end
    endtask

    task automatic add_filler(input int count);
        repeat (count) add_beat(8'($urandom_range(0, 255)));
    endtask

    task automatic add_record(input logic [7:0] typ, input logic [15:0] id,
                              input logic [15:0] clen, input logic [7:0] plen);
        add_header(typ, id, clen, plen);
        add_filler(clen);
        add_filler(plen);
    endtask

    function automatic logic [7:0] unknown_type();
        logic [7:0] typ;
        do begin
            typ = 8'($urandom_range(0, 255));
        end while (typ inside {TYPE_STDOUT, TYPE_STDERR, TYPE_END_REQUEST});
        return typ;
    endfunction

    function automatic logic [15:0] content_len(input int lo);
        if ($urandom_range(0, 9) == 0) return 16'($urandom_range(13, 60));
        return 16'($urandom_range(lo, 12));
    endfunction

    function automatic logic [7:0] pad_len();
        if ($urandom_range(0, 39) == 0) return 8'($urandom_range(8, 255));
        return 8'($urandom_range(0, 7));
    endfunction

    // stimulus and end of run
    initial begin
        int          pick;
        int          random_end;
        bit          mid_drain;
        logic [15:0] clen;
        logic [7:0]  plen;

        // directed: field extremes, each record type, restarts in every phase
        add_header(TYPE_STDOUT, 16'hFFFF, 16'd0, 8'd0);
        add_header(TYPE_STDOUT, 16'h0000, 16'd2, 8'd3);
        add_beat(8'h00);
        add_beat(8'hFF);
        add_filler(3);
        add_header(TYPE_STDERR, 16'h5A5A, 16'd1, 8'd0);
        add_beat(8'hA5);
        add_header(TYPE_STDERR, 16'h1234, 16'd0, 8'd2);
        add_filler(2);
        add_header(TYPE_END_REQUEST, 16'h00FF, 16'd0, 8'd0);
        add_record(TYPE_END_REQUEST, 16'hFF00, 16'd8, 8'd0);
        add_header(TYPE_STDOUT, 16'hABCD, 16'd0, 8'd0, 3);
        add_restart();
        add_record(TYPE_STDOUT, 16'h0001, 16'd1, 8'd0);
        add_header(8'hFF, 16'h7777, 16'd4, 8'd0);
        add_filler(3);
        add_restart();
        add_header(8'h00, 16'h0808, 16'd0, 8'd0);
        add_restart();
        add_header(TYPE_STDOUT, 16'h8001, 16'hFFFF, 8'hFF);
        add_filler(5);
        add_restart();
        add_record(TYPE_STDERR, 16'h4321, 16'd3, 8'hFF);
        add_header(TYPE_STDOUT, 16'h2468, 16'd1, 8'd4);
        add_filler(3);
        add_restart();

        // random: mostly well-formed records, some broken ones and noise
        drain_next = 1'b1;
        mid_drain  = 1'b0;
        random_end = pending_beats.size() + RANDOM_BEATS;
        while (pending_beats.size() < random_end) begin
            if (!mid_drain && pending_beats.size() > random_end - RANDOM_BEATS * 2 / 3) begin
                drain_next = 1'b1;
                mid_drain  = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_record(TYPE_STDOUT, 16'($urandom_range(0, 65535)), content_len(1), pad_len());
            end else if (pick < 55) begin
                add_record(TYPE_STDERR, 16'($urandom_range(0, 65535)), content_len(0), pad_len());
            end else if (pick < 65) begin
                add_record(TYPE_END_REQUEST, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 8)), pad_len());
            end else if (pick < 73) begin
                add_record(TYPE_STDOUT, 16'($urandom_range(0, 65535)), 16'd0, pad_len());
            end else if (pick < 80) begin
                // unknown type, bytes ignored while halted, then restart
                add_header(unknown_type(), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                add_filler($urandom_range(0, 5));
                add_restart();
            end else if (pick < 88) begin
                // record cut short in the header or the content
                clen = content_len(1);
                plen = pad_len();
                if ($urandom_range(0, 1) == 0) begin
                    add_header(TYPE_STDOUT, 16'($urandom_range(0, 65535)), clen, plen,
                               $urandom_range(1, 7));
                end else begin
                    add_header($urandom_range(0, 1) ? TYPE_STDERR : TYPE_END_REQUEST,
                               16'($urandom_range(0, 65535)), clen, plen);
                    add_filler($urandom_range(0, clen - 1));
                end
                add_restart();
            end else if (pick < 94) begin
                add_filler($urandom_range(1, 12));
                add_restart();
            end else begin
                add_restart();
            end
        end
        total_beats = pending_beats.size();

        while (beats_accepted != total_beats) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // driver: input beats, with random gaps and the drain pauses
    always @(posedge i_clk) begin
        t_result res;
        bit      offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer = i_in_valid;
            // accepted beat goes through the parser
            if (i_in_valid && o_in_ready) begin
                if (deframe_byte(cur_beat.data, cur_beat.restart, res)) begin
                    due_results.push_back(res);
                    results_due++;
                end
                beats_accepted <= beats_accepted + 1;
                drain_wait = DRAIN_CYCLES;
                offer = 1'b0;
            end
            // next beat, unless gapping or waiting for the block to drain
            if (!offer) begin
                if (sender_gap != 0) begin
                    sender_gap--;
                end else if (pending_beats.size() != 0) begin
                    if (pending_beats[0].drain_first) begin
                        if (results_due > results_seen) begin
                            drain_wait = DRAIN_CYCLES;
                        end else if (drain_wait != 0) begin
                            drain_wait--;
                        end else begin
                            pending_beats[0].drain_first = 1'b0;
                        end
                    end
                    if (!pending_beats[0].drain_first) begin
                        cur_beat = pending_beats.pop_front();
                        offer = 1'b1;
                        if (idle_allowed() && $urandom_range(0, 4) == 0) begin
                            sender_gap = $urandom_range(1, 19);
                        end
                    end
                end
            end
            i_in_valid  <= offer;
            i_data_byte <= cur_beat.data;
            i_restart   <= cur_beat.restart;
        end
    end

    // receiver ready: random stall bursts plus one long hold-off mid-run
    always @(posedge i_clk) begin
        bit rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            rdy = 1'b1;
            if (!holdoff_done && total_beats != 0 && beats_accepted >= total_beats / 2) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                rdy = 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(1, 19) - 1;
                rdy = 1'b0;
            end
            i_out_ready <= rdy;
        end
    end

    // monitor: compare each result beat with the oldest expected one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h id %04h",
                                          o_out_kind, o_out_byte, o_record_id));
            end else begin
                want = due_results.pop_front();
                if (o_out_kind !== want.out_kind) begin
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              o_out_kind, want.out_kind));
                end
                if (o_out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              o_out_byte, want.out_byte));
                end
                if (o_record_id !== want.record_id) begin
                    report_mismatch($sformatf("record id %04h, expected %04h",
                                              o_record_id, want.record_id));
                end
            end
        end
    end

endmodule

// ----- files.f -----
hw/rtl/fcgi_pkg.sv
hw/rtl/fcgi_step.sv
hw/rtl/fastcgi_record_deframer.sv
tb/tb_top.sv
